/* rtl/core/zbtcc_pkg.sv */
`timescale 1ns / 1ps

package zbtcc_pkg;

    // Screen geometry
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 128;
    localparam int ROW_W    = 6;
    localparam int COL_W    = 7;
    localparam int CELL_AW  = ROW_W + COL_W;
    localparam int CELLS    = MAX_ROWS * MAX_COLS;

    // Field and register widths
    localparam int ROWS_W  = 7;
    localparam int COLS_W  = 8;
    localparam int CHAR_W  = 8;
    localparam int DEPTH_W = 16;
    localparam int SPAN_W  = 8;

    // APB port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Register reset values
    localparam int ROWS_RESET = 25;
    localparam int COLS_RESET = 80;

    typedef enum logic [2:0] {
        FUNC_COMPOSITE   = 3'd0,
        FUNC_READ_SPAN   = 3'd1,
        FUNC_RESET_SPANS = 3'd2,
        FUNC_RELEASE     = 3'd3,
        FUNC_CLEAR       = 3'd4
    } func_t;

    typedef enum logic [0:0] {
        REG_ROWS_IN_USE = 1'b0,
        REG_COLS_IN_USE = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [2:0]         func;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [CHAR_W-1:0]  glyph;
        logic [CHAR_W-1:0]  attr;
        logic [DEPTH_W-1:0] depth;
    } in_t;

    typedef struct packed {
        logic              won;
        logic              changed;
        logic [SPAN_W-1:0] span_start;
        logic [SPAN_W-1:0] span_length;
    } out_t;

    typedef struct packed {
        logic [CHAR_W-1:0]  glyph;
        logic [CHAR_W-1:0]  attr;
        logic [DEPTH_W-1:0] depth;
    } cell_t;

    typedef struct packed {
        logic [SPAN_W-1:0] start;
        logic [SPAN_W-1:0] length;
    } span_t;

endpackage

/* rtl/core/zbuffer_text_cell_compositor_unit.sv */
`timescale 1ns / 1ps

// Channel   Handshake                 Payload      Notes
// --------  ------------------------  -----------  ---------------------------------
// in        in_valid / in_stall       in_data      one transaction per operation
// out       out_valid / out_stall     out_data     one result transaction per input
// cfg       psel/penable/pwrite/pready paddr/pwdata rows_in_use @0, cols_in_use @4
//
// Composite, span read and span reset read the cell and span memories at accept,
// then write back and load the output register in the ST_OP state.
// Release-layer and clear-depth walk rows_in_use x cols_in_use cells, clamped to
// the screen size, through the cell memory port, one cell per cycle.
// After reset a clearing pass zeroes all 8192 cells (in_stall high);
// configuration writes are taken throughout. A stalled output holds the write-back
// of the next composite or span operation until the output register frees up.

module zbuffer_text_cell_compositor_unit
    import zbtcc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    output logic              in_stall,
    input  in_t               in_data,

    output logic              out_valid,
    input  logic              out_stall,
    output out_t              out_data,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_OP,
        ST_WALK
    } state_t;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t               state_reg;
    in_t                  item_reg;
    logic                 hit_reg;
    logic [ROWS_W-1:0]    rows_reg;
    logic [COLS_W-1:0]    cols_reg;
    logic [SPAN_W-1:0]    span_base_reg;   // start value of rows with no valid span entry
    logic [MAX_ROWS-1:0]  span_vld_reg;
    logic [ROWS_W-1:0]    walk_row_reg;
    logic [COLS_W-1:0]    walk_col_reg;
    logic                 walk_issue_reg;
    logic                 pend_reg;
    logic [CELL_AW-1:0]   pend_addr_reg;
    logic [CELL_AW-1:0]   init_addr_reg;
    logic                 out_valid_reg;
    out_t                 out_data_reg;

    // Memories
    cell_t                cell_mem [CELLS];
    cell_t                cell_rd_reg;
    span_t                span_mem [MAX_ROWS];
    span_t                span_rd_reg;

    // ------------------------------------------------------------------
    // Combinational signals
    // ------------------------------------------------------------------
    logic [ROWS_W-1:0]    eff_rows;
    logic [COLS_W-1:0]    eff_cols;
    logic                 out_free;
    logic                 out_load;
    logic                 accept;
    logic                 in_hit;
    logic                 op_fire;
    logic                 walk_done;

    logic                 cell_re;
    logic [CELL_AW-1:0]   cell_raddr;
    logic                 cell_we;
    logic [CELL_AW-1:0]   cell_waddr;
    cell_t                cell_wdata;

    logic                 span_we;
    span_t                span_wdata;
    span_t                span_cur;

    logic                 op_won;
    logic                 op_changed;
    out_t                 op_result;

    logic [CELL_AW-1:0]   walk_addr;
    logic [COLS_W-1:0]    walk_col_inc;
    logic [ROWS_W-1:0]    walk_row_inc;
    logic                 walk_match;

    logic [SPAN_W:0]      s9;
    logic [SPAN_W:0]      l9;
    logic [SPAN_W:0]      c9;
    logic [SPAN_W:0]      end9;

    logic                 cfg_we;

    // Active geometry, clamped to the screen size
    assign eff_rows = (rows_reg > ROWS_W'(MAX_ROWS)) ? ROWS_W'(MAX_ROWS) : rows_reg;
    assign eff_cols = (cols_reg > COLS_W'(MAX_COLS)) ? COLS_W'(MAX_COLS) : cols_reg;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign op_fire  = (state_reg == ST_OP) && out_free;
    assign out_load = op_fire || ((state_reg == ST_WALK) && walk_done && out_free);

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Position check at accept time
    always_comb
    begin
        case (in_data.func)
            FUNC_COMPOSITE:
                in_hit = ({1'b0, in_data.row} < eff_rows) && ({1'b0, in_data.col} < eff_cols);
            FUNC_READ_SPAN:
                in_hit = ({1'b0, in_data.row} < eff_rows);
            default:
                in_hit = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Composite / span read step
    // ------------------------------------------------------------------
    assign span_cur = span_vld_reg[item_reg.row] ? span_rd_reg
                                                 : span_t'{start: span_base_reg, length: '0};

    assign op_won = hit_reg && (item_reg.func == FUNC_COMPOSITE)
                    && (cell_rd_reg.depth <= item_reg.depth);
    assign op_changed = op_won && ((cell_rd_reg.glyph != item_reg.glyph)
                                   || (cell_rd_reg.attr != item_reg.attr));

    // Span widening: clean row starts fresh, left hits keep the right end
    assign s9   = {1'b0, span_cur.start};
    assign l9   = {1'b0, span_cur.length};
    assign c9   = {2'b00, item_reg.col};
    assign end9 = s9 + l9;

    always_comb
    begin
        span_wdata = span_cur;
        if (span_cur.length == '0)
        begin
            span_wdata.start  = SPAN_W'(c9);
            span_wdata.length = SPAN_W'(1);
        end
        else if (s9 > c9)
        begin
            span_wdata.start  = SPAN_W'(c9);
            span_wdata.length = SPAN_W'(end9 - c9);
        end
        else if (end9 < c9 + 9'd1)
        begin
            span_wdata.length = SPAN_W'(c9 + 9'd1 - s9);
        end
    end

    assign span_we = op_fire && op_changed;

    always_comb
    begin
        op_result         = '0;
        op_result.won     = op_won;
        op_result.changed = op_changed;
        if (hit_reg && (item_reg.func == FUNC_READ_SPAN))
        begin
            op_result.span_start  = span_cur.start;
            op_result.span_length = span_cur.length;
        end
    end

    // ------------------------------------------------------------------
    // Depth walk (release layer / clear depths)
    // ------------------------------------------------------------------
    assign walk_addr    = {walk_row_reg[ROW_W-1:0], walk_col_reg[COL_W-1:0]};
    assign walk_col_inc = walk_col_reg + COLS_W'(1);
    assign walk_row_inc = walk_row_reg + ROWS_W'(1);
    assign walk_match   = (item_reg.func == FUNC_CLEAR) || (cell_rd_reg.depth == item_reg.depth);
    assign walk_done    = !walk_issue_reg && !pend_reg;

    // ------------------------------------------------------------------
    // Cell memory port control
    // ------------------------------------------------------------------
    assign cell_re    = accept || ((state_reg == ST_WALK) && walk_issue_reg);
    assign cell_raddr = (state_reg == ST_WALK) ? walk_addr : {in_data.row, in_data.col};

    always_comb
    begin
        cell_we    = 1'b0;
        cell_waddr = {item_reg.row, item_reg.col};
        cell_wdata = '{glyph: item_reg.glyph, attr: item_reg.attr, depth: item_reg.depth};
        unique case (state_reg)
            ST_INIT:
            begin
                cell_we    = 1'b1;
                cell_waddr = init_addr_reg;
                cell_wdata = '0;
            end
            ST_OP:
            begin
                cell_we = op_fire && op_won;
            end
            ST_WALK:
            begin
                // read-modify-write pipelined: write cell k while reading cell k+1
                cell_we    = pend_reg && walk_match;
                cell_waddr = pend_addr_reg;
                cell_wdata = '{glyph: cell_rd_reg.glyph, attr: cell_rd_reg.attr, depth: '0};
            end
            default:
            begin
                cell_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cell_we)
        begin
            cell_mem[cell_waddr] <= cell_wdata;
        end
        if (cell_re)
        begin
            cell_rd_reg <= cell_mem[cell_raddr];
        end
    end

    // Span memory: read at accept, written back in the op cycle
    always_ff @(posedge clk)
    begin
        if (span_we)
        begin
            span_mem[item_reg.row] <= span_wdata;
        end
        if (accept)
        begin
            span_rd_reg <= span_mem[in_data.row];
        end
    end

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_comb
    begin
        unique case (reg_idx_t'(paddr[2]))
            REG_ROWS_IN_USE: prdata = APB_DW'(rows_reg);
            REG_COLS_IN_USE: prdata = APB_DW'(cols_reg);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Control state machine and output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            item_reg       <= '0;
            hit_reg        <= 1'b0;
            rows_reg       <= ROWS_W'(ROWS_RESET);
            cols_reg       <= COLS_W'(COLS_RESET);
            span_base_reg  <= SPAN_W'(COLS_RESET);
            span_vld_reg   <= '0;
            walk_row_reg   <= '0;
            walk_col_reg   <= '0;
            walk_issue_reg <= 1'b0;
            pend_reg       <= 1'b0;
            pend_addr_reg  <= '0;
            init_addr_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (reg_idx_t'(paddr[2]))
                    REG_ROWS_IN_USE: rows_reg <= pwdata[ROWS_W-1:0];
                    REG_COLS_IN_USE: cols_reg <= pwdata[COLS_W-1:0];
                    default:         rows_reg <= rows_reg;
                endcase
            end

            if (!out_stall && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_INIT:
                begin
                    init_addr_reg <= init_addr_reg + CELL_AW'(1);
                    if (init_addr_reg == '1)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_IDLE:
                begin
                    if (accept)
                    begin
                        item_reg <= in_data;
                        hit_reg  <= in_hit;
                        if ((in_data.func == FUNC_RELEASE) || (in_data.func == FUNC_CLEAR))
                        begin
                            walk_row_reg   <= '0;
                            walk_col_reg   <= '0;
                            walk_issue_reg <= (eff_rows != '0) && (eff_cols != '0);
                            pend_reg       <= 1'b0;
                            state_reg      <= ST_WALK;
                        end
                        else
                        begin
                            state_reg <= ST_OP;
                        end
                    end
                end

                ST_OP:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= op_result;
                        if (item_reg.func == FUNC_RESET_SPANS)
                        begin
                            span_vld_reg  <= '0;
                            span_base_reg <= eff_cols;
                        end
                        else if (span_we)
                        begin
                            span_vld_reg[item_reg.row] <= 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end

                ST_WALK:
                begin
                    pend_reg      <= walk_issue_reg;
                    pend_addr_reg <= walk_addr;
                    if (walk_issue_reg)
                    begin
                        if (walk_col_inc == eff_cols)
                        begin
                            walk_col_reg <= '0;
                            walk_row_reg <= walk_row_inc;
                            if (walk_row_inc == eff_rows)
                            begin
                                walk_issue_reg <= 1'b0;
                            end
                        end
                        else
                        begin
                            walk_col_reg <= walk_col_inc;
                        end
                    end
                    if (walk_done && out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= '0;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
